// ===== hdl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg: shared definitions for the sorted minimum priority queue
// Field widths, command codes and status codes used by the queue, its
// channel interfaces and its checker.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Command codes carried in the cmd field of an input word.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes carried in the status field of a result word.
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

// ===== hdl/mpq_if.sv =====
// ----------------------------------------------------------------------------
// mpq_if: channel interfaces of the sorted minimum priority queue
// One interface for command words and one for result words, each a
// valid/ready channel with a source and a sink modport.
// ----------------------------------------------------------------------------
interface mpq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic signed [mpq_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mpq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mpq_pkg::DATA_W-1:0]   popped_value;
  logic        [mpq_pkg::STATUS_W-1:0] status;
  logic        [mpq_pkg::COUNT_W-1:0]  count;
  logic signed [mpq_pkg::DATA_W-1:0]   min_value;
  logic                                empty_res;

  modport source (output valid, output popped_value, output status, output count,
                  output min_value, output empty_res, input ready);
  modport sink   (input valid, input popped_value, input status, input count,
                  input min_value, input empty_res, output ready);
endinterface

// ===== hdl/mpq_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue: bounded sorted minimum priority queue
// Holds up to DEPTH signed values in ascending order in one RAM. A push
// inserts behind all equal values, a pop removes and returns the smallest.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Word contents
//   --------+-----------+-----------------------------------------------------
//   in_ch   | sink      | cmd (0 push, 1 pop), value (signed 32 bits)
//   out_ch  | source    | popped_value, status, count, min_value, empty_res
//
// One word is handled at a time; in_ch.ready is high only while the
// sequencer is idle. A push into an empty store writes the front entry
// directly; any other push scans from the rear and moves each entry greater
// than the new value back one place. A pop reads the front entry and moves
// every other entry forward one place. Moves share the single RAM read
// port: every entry that moves is read and written once. Dropped pushes and
// empty pops leave the RAM untouched. A finished result waits in the output
// register; the sequencer holds its last state until the output register is
// free. Reset (rst_n low, synchronous) empties the queue; the RAM contents
// are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module min_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  mpq_in_if.sink         in_ch,
  mpq_out_if.source      out_ch
);

  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int DW        = mpq_pkg::DATA_W;
  localparam int SW        = mpq_pkg::STATUS_W;
  localparam int CNT_OUT_W = mpq_pkg::COUNT_W;

  // Sequencer states. Each stored entry that has to move is handled in
  // PUSH_CMP or POP_SHIFT, where the read of the next entry overlaps the
  // write of the current one.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CMP,
    S_PUSH_PUT,
    S_POP_HEAD,
    S_POP_SHIFT,
    S_FETCH_MIN,
    S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [DW-1:0]        val_r, val_nxt;
  logic [DW-1:0]        popped_r, popped_nxt;
  logic [SW-1:0]        status_r, status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DW-1:0]        out_popped_r, out_popped_nxt;
  logic [SW-1:0]        out_status_r, out_status_nxt;
  logic [CNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic [DW-1:0]        out_min_r, out_min_nxt;
  logic                 out_empty_r, out_empty_nxt;

  // RAM port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;

  // Address arithmetic around the cursor and the count.
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        pos_m1;
  logic [CW-1:0]        pos_m2;
  logic [CW-1:0]        pos_p1;
  logic                 cmp_gt;

  mpq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1 = cnt_r - CW'(1);
  assign pos_m1 = pos_r - CW'(1);
  assign pos_m2 = pos_r - CW'(2);
  assign pos_p1 = pos_r + CW'(1);

  // The one comparator: is the entry just read strictly greater than
  // the value being inserted? Equal entries stay in front, which keeps ties
  // in arrival order.
  assign cmp_gt = $signed(ram_rdata) > $signed(val_r);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    popped_nxt     = popped_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_popped_nxt = out_popped_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          val_nxt    = in_ch.value;
          popped_nxt = '0;
          status_nxt = mpq_pkg::STAT_DONE;
          if (in_ch.cmd == mpq_pkg::CMD_PUSH) begin
            if (cnt_r == CW'(DEPTH)) begin
              status_nxt = mpq_pkg::STAT_FULL;
              state_nxt  = S_FETCH_MIN;
            end else if (cnt_r == '0) begin
              // First entry goes straight to the front.
              ram_we    = 1'b1;
              ram_wdata = in_ch.value;
              cnt_nxt   = CW'(1);
              state_nxt = S_FETCH_MIN;
            end else begin
              // Start the scan at the rear of the store.
              ram_re    = 1'b1;
              ram_raddr = cnt_m1[AW-1:0];
              pos_nxt   = cnt_r;
              state_nxt = S_PUSH_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = mpq_pkg::STAT_EMPTY;
              state_nxt  = S_FETCH_MIN;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_POP_HEAD;
            end
          end
        end
      end

      S_PUSH_CMP: begin
        // ram_rdata holds the entry just in front of the cursor.
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        if (cmp_gt) begin
          ram_wdata = ram_rdata;
          if (pos_r == CW'(1)) begin
            pos_nxt   = '0;
            state_nxt = S_PUSH_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_m2[AW-1:0];
            pos_nxt   = pos_m1;
          end
        end else begin
          ram_wdata = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_FETCH_MIN;
        end
      end

      S_PUSH_PUT: begin
        // Every stored entry was greater: the new value becomes the minimum.
        ram_we    = 1'b1;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_FETCH_MIN;
      end

      S_POP_HEAD: begin
        popped_nxt = ram_rdata;
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FETCH_MIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(1);
          pos_nxt   = CW'(1);
          state_nxt = S_POP_SHIFT;
        end
      end

      S_POP_SHIFT: begin
        // Move the entry at the cursor one place toward the front.
        ram_we    = 1'b1;
        ram_waddr = pos_m1[AW-1:0];
        ram_wdata = ram_rdata;
        if (pos_p1 < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = pos_p1[AW-1:0];
          pos_nxt   = pos_p1;
        end else begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_FETCH_MIN;
        end
      end

      S_FETCH_MIN: begin
        ram_re    = 1'b1;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        // The read data register holds the front entry until the next read,
        // so a stalled result can wait here.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = popped_r;
          out_status_nxt = status_r;
          out_count_nxt  = CNT_OUT_W'(cnt_r);
          out_min_nxt    = (cnt_r != '0) ? ram_rdata : '0;
          out_empty_nxt  = (cnt_r == '0);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    popped_r     <= popped_nxt;
    status_r     <= status_nxt;
    out_popped_r <= out_popped_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_min_r    <= out_min_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = out_popped_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.count        = out_count_r;
  assign out_ch.min_value    = out_min_r;
  assign out_ch.empty_res    = out_empty_r;

endmodule

// ===== hdl/mpq_chk.sv =====
// ----------------------------------------------------------------------------
// mpq_chk: port-level checker for the sorted minimum priority queue
// Watches the result channel and flags inconsistent or unstable words.
// ----------------------------------------------------------------------------
module mpq_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mpq_pkg::DATA_W-1:0]   out_popped_value,
  input logic        [mpq_pkg::STATUS_W-1:0] out_status,
  input logic        [mpq_pkg::COUNT_W-1:0]  out_count,
  input logic signed [mpq_pkg::DATA_W-1:0]   out_min_value,
  input logic                                out_empty_res
);

  // Only the three defined status codes ever appear.
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == mpq_pkg::STAT_DONE ||
                   out_status == mpq_pkg::STAT_FULL ||
                   out_status == mpq_pkg::STAT_EMPTY))
    else $error("result word carries an undefined status code");

  // An empty queue reports a zero minimum.
  a_empty_min : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_min_value == '0)
    else $error("empty queue reports a nonzero minimum");

  // A pop on an empty queue leaves it empty and returns nothing.
  a_empty_pop : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mpq_pkg::STAT_EMPTY |->
      out_empty_res && out_popped_value == '0)
    else $error("pop on empty queue reports data");

  // A stalled result word holds.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_value) &&
      $stable(out_status) && $stable(out_count) && $stable(out_min_value) &&
      $stable(out_empty_res))
    else $error("stalled result word changed");

endmodule

bind min_priority_queue mpq_chk u_mpq_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_popped_value (out_ch.popped_value),
  .out_status       (out_ch.status),
  .out_count        (out_ch.count),
  .out_min_value    (out_ch.min_value),
  .out_empty_res    (out_ch.empty_res)
);
